// File: rtl/ptsc_pkg.sv
// Shared types, constants and helpers for the pressure/temperature compensation pipeline.
package ptsc_pkg;

    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_T1   = 3'd0;
    localparam logic [2:0] REG_T2   = 3'd1;
    localparam logic [2:0] REG_T3   = 3'd2;
    localparam logic [2:0] REG_P123 = 3'd3;
    localparam logic [2:0] REG_P456 = 3'd4;
    localparam logic [2:0] REG_P789 = 3'd5;

    localparam logic [31:0] C_64000   = 32'd64000;
    localparam logic [31:0] C_1048576 = 32'd1048576;
    localparam logic [31:0] C_3125    = 32'd3125;
    localparam logic [31:0] C_32768   = 32'd32768;
    localparam logic [31:0] C_128     = 32'd128;

    typedef logic [31:0] t_word;

    // One divider stage: partial remainder, dividend/quotient shift word and side data
    typedef struct packed {
        t_word rem;
        t_word num;
        t_word den;
        logic  dbl;
        logic  zero;
        t_word temp;
    } t_div_st;

    function automatic t_word asr32(input t_word x, input int unsigned n);
        asr32 = t_word'($signed(x) >>> n);
    endfunction

    function automatic t_word sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

// File: rtl/ptsc_if.sv
// Valid/ready channel interfaces for raw samples and compensated results.
interface ptsc_smp_if;
    logic       valid;
    logic       ready;
    logic [7:0] pres_msb;
    logic [7:0] pres_lsb;
    logic [7:0] pres_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;

    modport source (output valid, pres_msb, pres_lsb, pres_xlsb, temp_msb, temp_lsb,
                    temp_xlsb, input ready);
    modport sink   (input valid, pres_msb, pres_lsb, pres_xlsb, temp_msb, temp_lsb,
                    temp_xlsb, output ready);
endinterface

interface ptsc_res_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] temperature_centi;
    logic        [31:0] pressure_pa;
    logic               pressure_valid;

    modport source (output valid, temperature_centi, pressure_pa, pressure_valid,
                    input ready);
    modport sink   (input valid, temperature_centi, pressure_pa, pressure_valid,
                    output ready);
endinterface

// File: rtl/pressure_temp_sensor_compensation_unit.sv
// Top level: 48-stage pipelined integer compensation of raw barometric samples.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------------
//  i_smp    | in  | valid/ready          | pres_msb/lsb/xlsb, temp_msb/lsb/xlsb
//  o_res    | out | valid/ready          | temperature_centi, pressure_pa, pressure_valid
//  APB      | in  | psel/penable/pwrite  | paddr[5:0], pwdata/prdata 64b, 8*index
//
// One sample per cycle sustained while o_res.ready is high.
// Stages: 11 for temperature and divisor/numerator, 1 divide setup, 32 for the
// restoring divider (one quotient bit per stage), 4 for the pressure polish.
// Reset (i_rst_n low, synchronous) clears stage valid bits and trim registers.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse under output backpressure and nothing is dropped or repeated.
module pressure_temp_sensor_compensation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ptsc_smp_if.sink                      i_smp,
    ptsc_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ptsc_pkg::DATA_W-1:0]   pwdata,
    output logic [ptsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import ptsc_pkg::*;

    localparam int NS   = 48;   // total stages
    localparam int DIV0 = 13;   // first divider stage
    localparam int NDIV = 32;

    // ---------------- trim registers ----------------
    logic [15:0] r_t1, r_t2, r_t3;
    logic [47:0] r_p123, r_p456, r_p789;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1   <= '0;
            r_t2   <= '0;
            r_t3   <= '0;
            r_p123 <= '0;
            r_p456 <= '0;
            r_p789 <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_T1:   r_t1   <= pwdata[15:0];
                REG_T2:   r_t2   <= pwdata[15:0];
                REG_T3:   r_t3   <= pwdata[15:0];
                REG_P123: r_p123 <= pwdata[47:0];
                REG_P456: r_p456 <= pwdata[47:0];
                REG_P789: r_p789 <= pwdata[47:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_T1:   prdata = {48'd0, r_t1};
            REG_T2:   prdata = {48'd0, r_t2};
            REG_T3:   prdata = {48'd0, r_t3};
            REG_P123: prdata = {16'd0, r_p123};
            REG_P456: prdata = {16'd0, r_p456};
            REG_P789: prdata = {16'd0, r_p789};
            default:  prdata = '0;
        endcase
    end

    // Coefficients extended to words: T1 and P1 zero-extended, the others sign-extended
    t_word t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_t1};
    assign t2 = sx16(r_t2);
    assign t3 = sx16(r_t3);
    assign p1 = {16'd0, r_p123[15:0]};
    assign p2 = sx16(r_p123[31:16]);
    assign p3 = sx16(r_p123[47:32]);
    assign p4 = sx16(r_p456[15:0]);
    assign p5 = sx16(r_p456[31:16]);
    assign p6 = sx16(r_p456[47:32]);
    assign p7 = sx16(r_p789[15:0]);
    assign p8 = sx16(r_p789[31:16]);
    assign p9 = sx16(r_p789[47:32]);

    // ---------------- flow control ----------------
    // en[k]: stage k loads this cycle. Ready ripples back from the output.
    logic [NS:1] r_vld;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !r_vld[NS] || o_res.ready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_smp.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_smp.valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- temperature path ----------------
    logic [19:0] adc_t, adc_p;
    assign adc_t = {i_smp.temp_msb, i_smp.temp_lsb, i_smp.temp_xlsb[7:4]};
    assign adc_p = {i_smp.pres_msb, i_smp.pres_lsb, i_smp.pres_xlsb[7:4]};

    logic [19:0] r1_adcp, r2_adcp, r3_adcp, r4_adcp, r5_adcp, r6_adcp, r7_adcp, r8_adcp,
                 r9_adcp;
    t_word r1_x1, r1_d;
    t_word r2_m1, r2_dd;
    t_word r3_a, r3_mb;
    t_word r4_fine;
    t_word r5_temp, r5_v1;
    t_word r6_q, r6_m5, r6_m2, r6_temp;
    t_word r7_v2a, r7_m3, r7_m5, r7_m2, r7_temp;
    t_word r8_v2, r8_v1, r8_temp;
    t_word r9_m, r9_v2, r9_temp;
    t_word r10_div, r10_pp, r10_temp;
    t_word r11_pm, r11_div, r11_temp;
    t_word n5_temp, h6;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_x1   <= {15'd0, adc_t[19:3]} - {t1[30:0], 1'b0};
            r1_d    <= {16'd0, adc_t[19:4]} - t1;
            r1_adcp <= adc_p;
        end
        if (en[2]) begin
            r2_m1   <= r1_x1 * t2;
            r2_dd   <= r1_d * r1_d;
            r2_adcp <= r1_adcp;
        end
        if (en[3]) begin
            r3_a    <= asr32(r2_m1, 11);
            r3_mb   <= asr32(r2_dd, 12) * t3;
            r3_adcp <= r2_adcp;
        end
        if (en[4]) begin
            r4_fine <= r3_a + asr32(r3_mb, 14);
            r4_adcp <= r3_adcp;
        end
        if (en[5]) begin
            r5_temp <= asr32(n5_temp, 8);
            r5_v1   <= asr32(r4_fine, 1) - C_64000;
            r5_adcp <= r4_adcp;
        end
        if (en[6]) begin
            r6_q    <= h6 * h6;
            r6_m5   <= r5_v1 * p5;
            r6_m2   <= p2 * r5_v1;
            r6_temp <= r5_temp;
            r6_adcp <= r5_adcp;
        end
        if (en[7]) begin
            r7_v2a  <= asr32(r6_q, 11) * p6;
            r7_m3   <= p3 * asr32(r6_q, 13);
            r7_m5   <= r6_m5;
            r7_m2   <= r6_m2;
            r7_temp <= r6_temp;
            r7_adcp <= r6_adcp;
        end
        if (en[8]) begin
            r8_v2   <= asr32(r7_v2a + {r7_m5[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
            r8_v1   <= asr32(asr32(r7_m3, 3) + asr32(r7_m2, 1), 18);
            r8_temp <= r7_temp;
            r8_adcp <= r7_adcp;
        end
        if (en[9]) begin
            r9_m    <= (C_32768 + r8_v1) * p1;
            r9_v2   <= r8_v2;
            r9_temp <= r8_temp;
            r9_adcp <= r8_adcp;
        end
        if (en[10]) begin
            r10_div  <= asr32(r9_m, 15);
            r10_pp   <= (C_1048576 - {12'd0, r9_adcp}) - asr32(r9_v2, 12);
            r10_temp <= r9_temp;
        end
        if (en[11]) begin
            r11_pm   <= r10_pp * C_3125;
            r11_div  <= r10_div;
            r11_temp <= r10_temp;
        end
    end

    assign n5_temp = r4_fine * 32'd5 + C_128;
    assign h6      = asr32(r5_v1, 2);

    // ---------------- divider setup and stages ----------------
    // Numerator below 2^31 is doubled before dividing; otherwise the quotient is doubled.
    t_div_st r_div [DIV0-1:DIV0+NDIV-1];

    always_ff @(posedge i_clk) begin
        if (en[DIV0-1]) begin
            r_div[DIV0-1].rem  <= '0;
            r_div[DIV0-1].num  <= r11_pm[31] ? r11_pm : {r11_pm[30:0], 1'b0};
            r_div[DIV0-1].den  <= r11_div;
            r_div[DIV0-1].dbl  <= r11_pm[31];
            r_div[DIV0-1].zero <= (r11_div == '0);
            r_div[DIV0-1].temp <= r11_temp;
        end
    end

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        t_div_st    prv;
        logic [32:0] trial;
        logic [32:0] diff;
        logic        take;

        assign prv   = r_div[DIV0-1+j];
        assign trial = {prv.rem, prv.num[31]};
        assign diff  = trial - {1'b0, prv.den};
        assign take  = !diff[32];

        always_ff @(posedge i_clk) begin
            if (en[DIV0+j]) begin
                r_div[DIV0+j].rem  <= take ? diff[31:0] : trial[31:0];
                r_div[DIV0+j].num  <= {prv.num[30:0], take};
                r_div[DIV0+j].den  <= prv.den;
                r_div[DIV0+j].dbl  <= prv.dbl;
                r_div[DIV0+j].zero <= prv.zero;
                r_div[DIV0+j].temp <= prv.temp;
            end
        end
    end

    // ---------------- pressure polish ----------------
    localparam int SP = DIV0 + NDIV;   // 45
    t_div_st last;
    assign last = r_div[SP-1];

    t_word r45_p, r45_temp;
    logic  r45_zero;
    t_word r46_p, r46_s, r46_m8, r46_temp;
    logic  r46_zero;
    t_word r47_p, r47_a, r47_b, r47_temp;
    logic  r47_zero;
    t_word r_temp_o, r_pres_o;
    logic  r_pval_o;
    t_word p3s, sum47;

    assign p3s   = {3'd0, r45_p[31:3]};
    assign sum47 = r47_a + r47_b + p7;

    always_ff @(posedge i_clk) begin
        if (en[SP]) begin
            r45_p    <= last.dbl ? {last.num[30:0], 1'b0} : last.num;
            r45_zero <= last.zero;
            r45_temp <= last.temp;
        end
        if (en[SP+1]) begin
            r46_s    <= p3s * p3s;
            r46_m8   <= {2'd0, r45_p[31:2]} * p8;
            r46_p    <= r45_p;
            r46_zero <= r45_zero;
            r46_temp <= r45_temp;
        end
        if (en[SP+2]) begin
            r47_a    <= asr32(p9 * {13'd0, r46_s[31:13]}, 12);
            r47_b    <= asr32(r46_m8, 13);
            r47_p    <= r46_p;
            r47_zero <= r46_zero;
            r47_temp <= r46_temp;
        end
        if (en[NS]) begin
            r_temp_o <= r47_temp;
            r_pres_o <= r47_zero ? '0 : (r47_p + asr32(sum47, 4));
            r_pval_o <= !r47_zero;
        end
    end

    assign o_res.valid             = r_vld[NS];
    assign o_res.temperature_centi = $signed(r_temp_o);
    assign o_res.pressure_pa       = r_pres_o;
    assign o_res.pressure_valid    = r_pval_o;

endmodule

// File: rtl/ptsc_chk.sv
// Port-level checker for the compensation unit, bound to the top level.
module ptsc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_pres,
    input logic        i_out_pval,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [5:0]  i_paddr,
    input logic [63:0] i_pwdata,
    input logic [63:0] i_prdata
);
    localparam int LAT = 48;

    // Stalled result stays valid and its pressure holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pres))
        else $error("result changed while stalled");

    // Zero divisor means zero pressure
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_pval |-> i_out_pres == 32'd0)
        else $error("invalid pressure not zero");

    // No result can emerge sooner than the pipeline depth after reset
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n, LAT - 1) |-> !i_out_valid)
        else $error("result earlier than pipeline latency");

    // Register 0 reads back what was written
    a_rdbk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && i_paddr[5:3] == 3'd0
        |=> (i_paddr[5:3] != 3'd0) || (i_prdata[15:0] == $past(i_pwdata[15:0])))
        else $error("trim T1 readback mismatch");

endmodule

bind pressure_temp_sensor_compensation_unit ptsc_chk u_ptsc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_pres  (o_res.pressure_pa),
    .i_out_pval  (o_res.pressure_valid),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);
